/* rtl/unbt_pkg.sv */
// ----------------------------------------------------------------------------
// unbt_pkg: shared types and constants of the user id binding table
// Table size, command and status codes, queue item and table entry layouts.
// ----------------------------------------------------------------------------
package unbt_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int ADDR_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   localparam logic [31:0] MIN_USER_ID_RESET = 32'd10000;
   localparam logic [7:0]  PROTO_UDP         = 8'd17;
   localparam logic [7:0]  PROTO_UDPLITE     = 8'd136;
   localparam int          STRAT_SEND_BIT    = 1;
   localparam int          STRAT_RECV_BIT    = 2;

   typedef enum logic [2:0] {
      CMD_BIND       = 3'd0,
      CMD_UNBIND     = 3'd1,
      CMD_CLOSE      = 3'd2,
      CMD_UDP_LOOKUP = 3'd3,
      CMD_SEND_CHECK = 3'd4,
      CMD_RECV_CHECK = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      ST_DONE      = 3'd0,
      ST_BELOW_MIN = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_NOT_UDP   = 3'd4
   } status_type;

   // Classified command waiting for the table engine.
   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] user_id;
      logic [31:0] network_id;
      logic [2:0]  close_strategy;
      logic [31:0] birth_time;
      logic [31:0] current_time;
      logic        early;
      status_type  early_status;
   } item_type;

   typedef struct packed {
      logic [31:0] user_id;
      logic [31:0] network_id;
      logic [2:0]  strategy;
      logic [31:0] bind_time;
   } entry_type;

endpackage

/* rtl/unbt_req_if.sv */
// ----------------------------------------------------------------------------
// unbt_req_if: command channel
// Valid/ready channel carrying one table command per transfer.
// ----------------------------------------------------------------------------
interface unbt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [31:0] user_id;
   logic [31:0] network_id;
   logic [2:0]  close_strategy;
   logic [7:0]  protocol;
   logic [31:0] birth_time;
   logic [31:0] current_time;

   modport source (output valid, command, user_id, network_id, close_strategy,
                   protocol, birth_time, current_time, input ready);
   modport sink   (input valid, command, user_id, network_id, close_strategy,
                   protocol, birth_time, current_time, output ready);
endinterface

/* rtl/unbt_rsp_if.sv */
// ----------------------------------------------------------------------------
// unbt_rsp_if: result channel
// Valid/ready channel carrying one command result per transfer.
// ----------------------------------------------------------------------------
interface unbt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        mark_valid;
   logic [31:0] mark_value;
   logic        pipe_error;
   logic [31:0] new_birth_time;

   modport source (output valid, status, mark_valid, mark_value, pipe_error,
                   new_birth_time, input ready);
   modport sink   (input valid, status, mark_valid, mark_value, pipe_error,
                   new_birth_time, output ready);
endinterface

/* rtl/uid_network_binding_table.sv */
// ----------------------------------------------------------------------------
// uid_network_binding_table: user id to network id binding table
// Binds, unbinds, closes, looks up and checks user ids in a bounded table.
// ----------------------------------------------------------------------------
//  channel    direction  handshake      payload
//  req_chan   in         valid/ready    command, ids, strategy, protocol, times
//  rsp_chan   out        valid/ready    status, mark, pipe error, birth time
//  csr_*      in         write enable   min_user_id
//
// Commands settled without the table are answered from the idle state; others scan
// the packed bindings, a read and a compare state per entry through the single
// memory read port, with a move state added for a refilling unbind.
// Reset is synchronous and empties the table through its fill count; no pass.
// A two-entry queue lets new commands transfer in while the engine is busy or
// the result waits to be taken.
// ----------------------------------------------------------------------------
module uid_network_binding_table (
   input  logic        clock,
   input  logic        reset,
   unbt_req_if.sink    req_chan,
   unbt_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import unbt_pkg::*;

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   unbt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   unbt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

/* rtl/unbt_front.sv */
// ----------------------------------------------------------------------------
// unbt_front: command intake and classification
// Holds the minimum user id register, settles commands that need no table
// access, and queues every command in a two-entry buffer for the engine.
// ----------------------------------------------------------------------------
module unbt_front (
   input  logic                 clock,
   input  logic                 reset,
   unbt_req_if.sink             req_chan,
   input  logic                 csr_wr_en,
   input  logic [31:0]          csr_wr_data,
   output logic                 q_valid,
   output unbt_pkg::item_type   q_item,
   input  logic                 q_pop
);
   import unbt_pkg::*;

   logic [31:0] min_uid_ff, min_uid_in;
   item_type    buf_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        push;
   logic        below_min;
   item_type    cls;

   assign req_chan.ready = (fill_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign below_min      = (req_chan.user_id < min_uid_ff);

   always_comb begin
      cls.command        = req_chan.command;
      cls.user_id        = req_chan.user_id;
      cls.network_id     = req_chan.network_id;
      cls.close_strategy = req_chan.close_strategy;
      cls.birth_time     = req_chan.birth_time;
      cls.current_time   = req_chan.current_time;
      cls.early          = 1'b0;
      cls.early_status   = ST_DONE;
      unique case (req_chan.command)
         CMD_BIND, CMD_UNBIND, CMD_CLOSE: begin
            cls.early        = below_min;
            cls.early_status = ST_BELOW_MIN;
         end
         CMD_UDP_LOOKUP: begin
            if (req_chan.protocol != PROTO_UDP && req_chan.protocol != PROTO_UDPLITE) begin
               cls.early        = 1'b1;
               cls.early_status = ST_NOT_UDP;
            end else if (below_min) begin
               cls.early        = 1'b1;
               cls.early_status = ST_BELOW_MIN;
            end
         end
         CMD_SEND_CHECK, CMD_RECV_CHECK: begin
            cls.early = 1'b0;
         end
         default: begin
            // Unused command codes finish at once with an all-zero result.
            cls.early = 1'b1;
         end
      endcase
   end

   always_comb begin
      min_uid_in = csr_wr_en ? csr_wr_data : min_uid_ff;
      wr_ptr_in  = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in    = fill_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_uid_ff <= MIN_USER_ID_RESET;
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
         fill_ff    <= 2'd0;
      end else begin
         min_uid_ff <= min_uid_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         fill_ff    <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= cls;
      end
   end

   assign q_valid = (fill_ff != 2'd0);
   assign q_item  = buf_ff[rd_ptr_ff];

endmodule

/* rtl/unbt_back.sv */
// ----------------------------------------------------------------------------
// unbt_back: table engine
// Keeps the bindings packed at the low addresses of a single-port memory,
// scans them for the key, applies the command and registers the result.
// ----------------------------------------------------------------------------
module unbt_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  unbt_pkg::item_type   q_item,
   output logic                 q_pop,
   unbt_rsp_if.source           rsp_chan
);
   import unbt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_READ    = 4'b0010,
      S_COMPARE = 4'b0100,
      S_MOVE    = 4'b1000
   } state_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        mark_valid;
      logic [31:0] mark_value;
      logic        pipe_error;
      logic [31:0] new_birth_time;
   } result_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   item_type          item_ff, item_in;
   item_type          cur;
   entry_type         mem [TABLE_ENTRIES];
   entry_type         rdata_ff;
   logic              rd_en, wr_en;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   entry_type         wr_data;
   logic              rsp_load;
   result_type        res;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff;
   logic              out_free;
   logic              is_check;
   logic              last_entry;
   logic [31:0]       age;
   logic              strat_hit;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign cur        = (state_ff == S_IDLE) ? q_item : item_ff;
   assign is_check   = (cur.command == CMD_SEND_CHECK) || (cur.command == CMD_RECV_CHECK);
   assign last_entry = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign age        = item_ff.birth_time - rdata_ff.bind_time;
   assign strat_hit  = (item_ff.command == CMD_SEND_CHECK) ? rdata_ff.strategy[STRAT_SEND_BIT]
                                                           : rdata_ff.strategy[STRAT_RECV_BIT];

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      item_in  = item_ff;
      q_pop    = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = idx_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = rdata_ff;
      rsp_load = 1'b0;
      res      = '0;
      unique case (state_ff)
         S_IDLE: begin
            // A command is taken only when the result register will be free.
            if (q_valid && out_free) begin
               q_pop   = 1'b1;
               item_in = q_item;
               if (q_item.early) begin
                  rsp_load   = 1'b1;
                  res.status = q_item.early_status;
               end else if (q_item.command == CMD_BIND && count_ff >= CNT_W'(TABLE_ENTRIES)) begin
                  rsp_load   = 1'b1;
                  res.status = ST_FULL;
               end else if (count_ff == '0) begin
                  rsp_load = 1'b1;
                  if (cur.command == CMD_BIND) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_data  = '{cur.user_id, cur.network_id, 3'd0, 32'd0};
                     count_in = count_ff + CNT_W'(1);
                     res.status = ST_DONE;
                  end else begin
                     res.status         = ST_NOT_FOUND;
                     res.new_birth_time = is_check ? cur.birth_time : 32'd0;
                  end
               end else begin
                  idx_in   = '0;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_COMPARE;
         end
         S_COMPARE: begin
            if (rdata_ff.user_id == item_ff.user_id) begin
               rsp_load   = 1'b1;
               res.status = ST_DONE;
               state_in   = S_IDLE;
               unique case (item_ff.command)
                  CMD_BIND: begin
                     wr_en   = 1'b1;
                     wr_data = '{item_ff.user_id, item_ff.network_id, 3'd0, 32'd0};
                  end
                  CMD_UNBIND: begin
                     if (last_entry) begin
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        // Refill the hole with the last entry to keep the table packed.
                        rsp_load = 1'b0;
                        rd_en    = 1'b1;
                        rd_addr  = ADDR_W'(count_ff - CNT_W'(1));
                        state_in = S_MOVE;
                     end
                  end
                  CMD_CLOSE: begin
                     wr_en   = 1'b1;
                     wr_data = '{rdata_ff.user_id, rdata_ff.network_id,
                                 item_ff.close_strategy, item_ff.current_time};
                  end
                  CMD_UDP_LOOKUP: begin
                     res.mark_valid = 1'b1;
                     res.mark_value = rdata_ff.network_id;
                  end
                  CMD_SEND_CHECK, CMD_RECV_CHECK: begin
                     // The socket is older than the close when the wrapped difference is negative.
                     if (age[31] && strat_hit) begin
                        res.pipe_error     = 1'b1;
                        res.new_birth_time = item_ff.current_time;
                     end else begin
                        res.new_birth_time = item_ff.birth_time;
                     end
                  end
                  default: begin
                     res.status = ST_DONE;
                  end
               endcase
            end else if (last_entry) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               if (item_ff.command == CMD_BIND) begin
                  wr_en      = 1'b1;
                  wr_addr    = ADDR_W'(count_ff);
                  wr_data    = '{item_ff.user_id, item_ff.network_id, 3'd0, 32'd0};
                  count_in   = count_ff + CNT_W'(1);
                  res.status = ST_DONE;
               end else begin
                  res.status         = ST_NOT_FOUND;
                  res.new_birth_time = is_check ? item_ff.birth_time : 32'd0;
               end
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               state_in = S_READ;
            end
         end
         S_MOVE: begin
            wr_en      = 1'b1;
            count_in   = count_ff - CNT_W'(1);
            rsp_load   = 1'b1;
            res.status = ST_DONE;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      item_ff <= item_in;
      if (rsp_load) begin
         rsp_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_ff.status;
   assign rsp_chan.mark_valid     = rsp_ff.mark_valid;
   assign rsp_chan.mark_value     = rsp_ff.mark_value;
   assign rsp_chan.pipe_error     = rsp_ff.pipe_error;
   assign rsp_chan.new_birth_time = rsp_ff.new_birth_time;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the user id to network id binding table
// Drives table commands with random gaps and stalls, predicts every result
// from a private copy of the table and the minimum user id, and compares
// each returned result field by field in the order the commands went in.
// ----------------------------------------------------------------------------
module tb_top;
   import unbt_pkg::*;

   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;
   localparam int         WATCHDOG_LIMIT = 20000;
   localparam int         LONG_HOLD_CYCLES = 400;

   typedef struct {
      logic [2:0]  command;
      logic [31:0] user_id;
      logic [31:0] network_id;
      logic [2:0]  close_strategy;
      logic [7:0]  protocol;
      logic [31:0] birth_time;
      logic [31:0] current_time;
   } table_cmd;

   typedef struct {
      logic [2:0]  status;
      logic        mark_valid;
      logic [31:0] mark_value;
      logic        pipe_error;
      logic [31:0] new_birth_time;
   } table_result;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [31:0] csr_wr_data;

   unbt_req_if req_chan ();
   unbt_rsp_if rsp_chan ();

   uid_network_binding_table u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Private copy of the table and its minimum user id.
   bit          bound_valid [TABLE_ENTRIES];
   logic [31:0] bound_user [TABLE_ENTRIES];
   logic [31:0] bound_network [TABLE_ENTRIES];
   logic [2:0]  bound_strategy [TABLE_ENTRIES];
   logic [31:0] bound_time [TABLE_ENTRIES];
   int          bound_count;
   logic [31:0] min_user;

   table_result awaited_results[$];
   int          mismatches;
   bit          quiet;
   bit          long_hold_req;
   int          hold_left;
   int          stall_left;
   int          idle_cycles;
   logic [31:0] tick_now;
   logic [31:0] uid_base;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int slot_of(logic [31:0] uid);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (bound_valid[i] && bound_user[i] == uid) return i;
      end
      return -1;
   endfunction

   function automatic int lowest_free();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (!bound_valid[i]) return i;
      end
      return -1;
   endfunction

   // Applies one command to the private table and returns its result.
   function automatic table_result apply_command(table_cmd c);
      table_result r;
      int s;
      logic [31:0] age;
      logic [2:0]  mask;
      r = '{status: ST_DONE, mark_valid: 1'b0, mark_value: '0, pipe_error: 1'b0,
            new_birth_time: '0};
      case (c.command)
         CMD_BIND: begin
            if (c.user_id < min_user) r.status = ST_BELOW_MIN;
            else if (bound_count >= TABLE_ENTRIES) r.status = ST_FULL;
            else begin
               s = slot_of(c.user_id);
               if (s < 0) begin
                  s = lowest_free();
                  bound_valid[s] = 1'b1;
                  bound_count++;
               end
               bound_user[s] = c.user_id;
               bound_network[s] = c.network_id;
               bound_strategy[s] = '0;
               bound_time[s] = '0;
            end
         end
         CMD_UNBIND: begin
            if (c.user_id < min_user) r.status = ST_BELOW_MIN;
            else begin
               s = slot_of(c.user_id);
               if (s < 0) r.status = ST_NOT_FOUND;
               else begin
                  bound_valid[s] = 1'b0;
                  bound_count--;
               end
            end
         end
         CMD_CLOSE: begin
            if (c.user_id < min_user) r.status = ST_BELOW_MIN;
            else begin
               s = slot_of(c.user_id);
               if (s < 0) r.status = ST_NOT_FOUND;
               else begin
                  bound_strategy[s] = c.close_strategy;
                  bound_time[s] = c.current_time;
               end
            end
         end
         CMD_UDP_LOOKUP: begin
            if (c.protocol != PROTO_UDP && c.protocol != PROTO_UDPLITE)
               r.status = ST_NOT_UDP;
            else if (c.user_id < min_user) r.status = ST_BELOW_MIN;
            else begin
               s = slot_of(c.user_id);
               if (s < 0) r.status = ST_NOT_FOUND;
               else begin
                  r.mark_valid = 1'b1;
                  r.mark_value = bound_network[s];
               end
            end
         end
         CMD_SEND_CHECK, CMD_RECV_CHECK: begin
            r.new_birth_time = c.birth_time;
            s = slot_of(c.user_id);
            if (s < 0) r.status = ST_NOT_FOUND;
            else begin
               // Born before the bind time means a negative wrapped difference.
               age = c.birth_time - bound_time[s];
               mask = '0;
               mask[(c.command == CMD_SEND_CHECK) ? STRAT_SEND_BIT : STRAT_RECV_BIT] = 1'b1;
               if (age[31] && (bound_strategy[s] & mask) != '0) begin
                  r.pipe_error = 1'b1;
                  r.new_birth_time = c.current_time;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_command(table_cmd c);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.command <= c.command;
      req_chan.user_id <= c.user_id;
      req_chan.network_id <= c.network_id;
      req_chan.close_strategy <= c.close_strategy;
      req_chan.protocol <= c.protocol;
      req_chan.birth_time <= c.birth_time;
      req_chan.current_time <= c.current_time;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      awaited_results.push_back(apply_command(c));
   endtask

   task automatic send_fields(logic [2:0] cmd, logic [31:0] uid, logic [31:0] nid,
                              logic [2:0] strat, logic [7:0] proto,
                              logic [31:0] birth, logic [31:0] now);
      table_cmd c;
      c = '{cmd, uid, nid, strat, proto, birth, now};
      send_command(c);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (awaited_results.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_min_user(logic [31:0] value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      min_user = value;
      uid_base = (value > 32'hFFFF_FFE0) ? 32'hFFFF_FFE0 : value;
   endtask

   function automatic logic [31:0] pick_uid();
      if ($urandom_range(0, 99) < 88) return uid_base + $urandom_range(0, 23);
      return $urandom;
   endfunction

   function automatic table_cmd random_command();
      table_cmd c;
      int pick;
      pick = $urandom_range(0, 99);
      c.user_id = pick_uid();
      c.network_id = $urandom;
      c.close_strategy = 3'($urandom_range(0, 7));
      c.protocol = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                   ($urandom_range(0, 1) ? PROTO_UDP : PROTO_UDPLITE);
      tick_now = tick_now + $urandom_range(0, 40);
      c.current_time = ($urandom_range(0, 15) == 0) ? $urandom : tick_now;
      c.birth_time = ($urandom_range(0, 15) == 0) ? $urandom
                     : tick_now + $urandom_range(0, 200) - 100;
      if (pick < 18) c.command = CMD_BIND;
      else if (pick < 26) c.command = CMD_UNBIND;
      else if (pick < 42) c.command = CMD_CLOSE;
      else if (pick < 62) c.command = CMD_UDP_LOOKUP;
      else if (pick < 79) c.command = CMD_SEND_CHECK;
      else if (pick < 96) c.command = CMD_RECV_CHECK;
      else c.command = pick[0] ? CMD_SPARE_6 : CMD_SPARE_7;
      return c;
   endfunction

   task automatic send_random(int count);
      for (int i = 0; i < count; i++) send_command(random_command());
   endtask

   // Result side: stall bursts, the long hold, the check and the watchdog.
   always @(posedge clock) begin
      if (rsp_chan.valid && rsp_chan.ready) begin
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result, status %0d", rsp_chan.status);
         end else begin
            table_result e;
            e = awaited_results.pop_front();
            if (rsp_chan.status !== e.status || rsp_chan.mark_valid !== e.mark_valid ||
                rsp_chan.mark_value !== e.mark_value ||
                rsp_chan.pipe_error !== e.pipe_error ||
                rsp_chan.new_birth_time !== e.new_birth_time) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %0d %0b %h %0b %h, got %0d %0b %h %0b %h",
                           e.status, e.mark_valid, e.mark_value, e.pipe_error,
                           e.new_birth_time, rsp_chan.status, rsp_chan.mark_valid,
                           rsp_chan.mark_value, rsp_chan.pipe_error,
                           rsp_chan.new_birth_time);
            end
         end
      end
      if (reset) rsp_chan.ready <= 1'b0;
      else if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = LONG_HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 12) - 1;
         rsp_chan.ready <= 1'b0;
      end else rsp_chan.ready <= 1'b1;

      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles = 0;
      else if (!reset) idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic test_directed();
      logic [31:0] u;
      u = MIN_USER_ID_RESET;
      send_fields(CMD_BIND, u - 1, 32'h1, 3'd0, 8'd0, '0, '0);
      send_fields(CMD_BIND, u, 32'hFFFF_FFFF, 3'd7, 8'hFF, '1, '1);
      send_fields(CMD_BIND, 32'hFFFF_FFFF, 32'h0, 3'd0, 8'd0, '0, '0);
      send_fields(CMD_UDP_LOOKUP, u, '0, 3'd0, PROTO_UDP, '0, '0);
      send_fields(CMD_UDP_LOOKUP, 32'hFFFF_FFFF, '0, 3'd0, PROTO_UDPLITE, '0, '0);
      send_fields(CMD_UDP_LOOKUP, u, '0, 3'd0, 8'd0, '0, '0);
      send_fields(CMD_UDP_LOOKUP, 32'd0, '0, 3'd0, 8'hFF, '0, '0);
      send_fields(CMD_UDP_LOOKUP, 32'd0, '0, 3'd0, PROTO_UDP, '0, '0);
      send_fields(CMD_UDP_LOOKUP, u + 5, '0, 3'd0, PROTO_UDP, '0, '0);
      send_fields(CMD_CLOSE, u, '0, 3'd7, '0, '0, 32'd1000);
      send_fields(CMD_SEND_CHECK, u, '0, 3'd0, '0, 32'd999, 32'h1234_5678);
      send_fields(CMD_RECV_CHECK, u, '0, 3'd0, '0, 32'd1000, 32'h1234_5678);
      send_fields(CMD_SEND_CHECK, u, '0, 3'd0, '0, 32'h8000_03E8, '1);
      send_fields(CMD_CLOSE, 32'hFFFF_FFFF, '0, 3'd2, '0, '0, 32'd0);
      send_fields(CMD_SEND_CHECK, 32'hFFFF_FFFF, '0, 3'd0, '0, 32'hFFFF_FFFF, 32'd7);
      send_fields(CMD_RECV_CHECK, 32'hFFFF_FFFF, '0, 3'd0, '0, 32'hFFFF_FFFF, 32'd7);
      send_fields(CMD_RECV_CHECK, u + 9, '0, 3'd0, '0, 32'd5, 32'd6);
      send_fields(CMD_CLOSE, u + 9, '0, 3'd4, '0, '0, '0);
      send_fields(CMD_BIND, u, 32'h5A5A_A5A5, 3'd0, '0, '0, '0);
      send_fields(CMD_SEND_CHECK, u, '0, 3'd0, '0, 32'hF000_0000, 32'd1);
      send_fields(CMD_UNBIND, u, '0, 3'd0, '0, '0, '0);
      send_fields(CMD_UNBIND, u, '0, 3'd0, '0, '0, '0);
      send_fields(CMD_UNBIND, 32'd5, '0, 3'd0, '0, '0, '0);
      send_fields(CMD_SPARE_6, '1, '1, 3'd7, 8'hFF, '1, '1);
      send_fields(CMD_SPARE_7, u, '0, 3'd0, '0, '0, '0);
   endtask

   // Checks ignore the minimum, so an entry under a raised minimum still hits.
   task automatic test_min_settings();
      write_min_user(32'd0);
      send_fields(CMD_BIND, 32'd0, 32'hCAFE_0000, 3'd0, '0, '0, '0);
      send_random(40);
      write_min_user(32'hFFFF_FFFF);
      send_fields(CMD_SEND_CHECK, 32'd0, '0, 3'd0, '0, '0, '0);
      send_fields(CMD_UNBIND, 32'd0, '0, 3'd0, '0, '0, '0);
      send_random(20);
      write_min_user($urandom);
      send_random(40);
      write_min_user(MIN_USER_ID_RESET);
   endtask

   task automatic test_long_hold();
      long_hold_req = 1'b1;
      send_random(30);
   endtask

   task automatic test_pause_until_drained();
      send_random(20);
      req_chan.valid <= 1'b0;
      while (awaited_results.size() > 0) @(posedge clock);
      send_random(20);
   endtask

   task automatic test_random_mix();
      send_random(80);
      quiet = 1'b1;
      send_random(60);
   endtask

   // Fill every slot, then show that binds are refused, bound user ids too.
   task automatic test_full_table();
      logic [31:0] uid;
      uid = 32'hA000_0000;
      while (bound_count < TABLE_ENTRIES) begin
         send_fields(CMD_BIND, uid, uid ^ 32'h5555_5555, 3'd0, '0, '0, '0);
         uid++;
      end
      send_fields(CMD_BIND, uid, '1, 3'd0, '0, '0, '0);
      send_fields(CMD_BIND, 32'hA000_0000, '1, 3'd0, '0, '0, '0);
      send_fields(CMD_UDP_LOOKUP, 32'hA000_0000, '0, 3'd0, PROTO_UDP, '0, '0);
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.command = '0;
      req_chan.user_id = '0;
      req_chan.network_id = '0;
      req_chan.close_strategy = '0;
      req_chan.protocol = '0;
      req_chan.birth_time = '0;
      req_chan.current_time = '0;
      rsp_chan.ready = 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) bound_valid[i] = 1'b0;
      bound_count = 0;
      min_user = MIN_USER_ID_RESET;
      uid_base = MIN_USER_ID_RESET;
      mismatches = 0;
      quiet = 1'b0;
      long_hold_req = 1'b0;
      hold_left = 0;
      stall_left = 0;
      idle_cycles = 0;
      tick_now = $urandom;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_min_settings();
      test_long_hold();
      test_pause_until_drained();
      test_random_mix();
      test_full_table();

      req_chan.valid <= 1'b0;
      while (awaited_results.size() > 0) @(posedge clock);
      repeat (2 * TABLE_ENTRIES + 20) @(posedge clock);
      if (mismatches == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

/* sim.f */
rtl/unbt_pkg.sv
rtl/unbt_req_if.sv
rtl/unbt_rsp_if.sv
rtl/unbt_front.sv
rtl/unbt_back.sv
rtl/uid_network_binding_table.sv
tb/sv/tb_top.sv
